// ----- sv/mcbf_pkg.sv -----
// shared types and codes for the multi-channel byte fifo table
// no dependencies

package mcbf_pkg;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 12;

    localparam logic [FUNC_W-1:0] FN_CREATE = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLOSE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PIPE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam logic [FREE_W-1:0] FREE_MAX = 12'hfff;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic execute;
    } cmd_t;

endpackage

// ----- sv/mcbf_ctrl.sv -----
// sequencing state machine for the fifo table: accept, pointer lookup, execute
// depends on mcbf_pkg

module mcbf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output mcbf_pkg::cmd_t  cmd
);

    mcbf_pkg::state_t state_reg;
    mcbf_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != mcbf_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.capture = (state_reg == mcbf_pkg::S_IDLE) && in_valid;
    assign cmd.lookup  = (state_reg == mcbf_pkg::S_LOOK);
    assign cmd.execute = (state_reg == mcbf_pkg::S_EXEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcbf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mcbf_pkg::S_LOOK;
                end
            end
            mcbf_pkg::S_LOOK:
            begin
                state_next = mcbf_pkg::S_EXEC;
            end
            mcbf_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = mcbf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mcbf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcbf_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == mcbf_pkg::S_LOOK))
        else $error("accepted word did not move to lookup");

    a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == mcbf_pkg::S_EXEC))
        else $error("result raised outside execute");

    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mcbf_pkg::S_EXEC) && out_valid_reg && out_stall)
        |=> (state_reg == mcbf_pkg::S_EXEC))
        else $error("execute overran a waiting result");

endmodule

// ----- sv/mcbf_dpath.sv -----
// datapath of the fifo table: slot flags, pointer tables, byte store, result register
// depends on mcbf_pkg

module mcbf_dpath
#(
    parameter int NUM_PIPES  = 16,
    parameter int PIPE_DEPTH = 4096
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  mcbf_pkg::cmd_t                   cmd,
    input  logic [mcbf_pkg::FUNC_W-1:0]      func,
    input  logic [mcbf_pkg::ID_W-1:0]        pipe_id,
    input  logic [mcbf_pkg::BYTE_W-1:0]      data_in,
    input  logic                             last_in_call,
    output logic [mcbf_pkg::STATUS_W-1:0]    status,
    output logic [mcbf_pkg::ID_W-1:0]        pipe_out,
    output logic [mcbf_pkg::BYTE_W-1:0]      data_out,
    output logic [mcbf_pkg::FREE_W-1:0]      bytes_free,
    output logic                             has_data,
    output logic                             last_out
);

    localparam int IW        = $clog2(NUM_PIPES);
    localparam int PW        = $clog2(PIPE_DEPTH);
    localparam int MEM_DEPTH = NUM_PIPES * PIPE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    // captured word
    logic [mcbf_pkg::FUNC_W-1:0]   func_reg;
    logic [mcbf_pkg::ID_W-1:0]     id_reg;
    logic [mcbf_pkg::BYTE_W-1:0]   din_reg;
    logic                          last_reg;

    // slot flags and lowest free slot
    logic [NUM_PIPES-1:0]          in_use_reg;
    logic [NUM_PIPES-1:0]          in_use_next;
    logic [IW-1:0]                 free_idx_c;
    logic                          free_any_c;
    logic [IW-1:0]                 free_idx_reg;
    logic                          free_any_reg;

    // pointer tables
    logic [PW-1:0]                 rp_mem [NUM_PIPES];
    logic [PW-1:0]                 wp_mem [NUM_PIPES];
    logic [PW-1:0]                 rp_q;
    logic [PW-1:0]                 wp_q;

    // lookup stage
    logic [IW-1:0]                 id_idx;
    logic                          id_ok;
    logic                          is_create;
    logic [IW-1:0]                 target_c;
    logic                          live_c;
    logic [IW-1:0]                 target_reg;
    logic                          live_reg;
    logic                          create_ok_reg;
    logic [AW-1:0]                 base_reg;

    // execute stage
    logic [PW-1:0]                 rp_cur;
    logic [PW-1:0]                 wp_cur;
    logic [PW-1:0]                 rp_adv;
    logic [PW-1:0]                 wp_adv;
    logic [PW-1:0]                 rp_new;
    logic [PW-1:0]                 wp_new;
    logic                          full;
    logic                          empty;
    logic                          report;
    logic                          do_write;
    logic                          do_read;
    logic                          clr_use;
    logic [mcbf_pkg::STATUS_W-1:0] status_c;
    logic [mcbf_pkg::ID_W-1:0]     pout_c;
    logic [PW:0]                   fv_c;
    logic [mcbf_pkg::FREE_W-1:0]   free_sat;
    logic [mcbf_pkg::FREE_W-1:0]   free_c;
    logic                          hasd_c;
    logic [AW-1:0]                 addr_c;

    // byte store and result register
    logic [mcbf_pkg::BYTE_W-1:0]   byte_mem [MEM_DEPTH];
    logic [mcbf_pkg::BYTE_W-1:0]   rdata_reg;
    logic                          rdok_reg;
    logic [mcbf_pkg::STATUS_W-1:0] status_reg;
    logic [mcbf_pkg::ID_W-1:0]     pout_reg;
    logic [mcbf_pkg::FREE_W-1:0]   free_reg;
    logic                          hasd_reg;
    logic                          last_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            id_reg   <= pipe_id;
            din_reg  <= data_in;
            last_reg <= last_in_call;
        end
    end

    // lowest free slot, registered every cycle
    always_comb
    begin
        free_idx_c = '0;
        free_any_c = 1'b0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx_c = IW'(i);
                free_any_c = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_c;
        free_any_reg <= free_any_c;
    end

    assign id_idx    = IW'(id_reg);
    assign id_ok     = (32'(id_reg) < NUM_PIPES);
    assign is_create = (func_reg == mcbf_pkg::FN_CREATE);
    assign target_c  = is_create ? free_idx_reg : id_idx;
    assign live_c    = id_ok && in_use_reg[id_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            target_reg    <= target_c;
            live_reg      <= live_c;
            create_ok_reg <= is_create && free_any_reg;
            base_reg      <= AW'(target_c * PIPE_DEPTH);
        end
    end

    // operation decode
    assign rp_cur = create_ok_reg ? '0 : rp_q;
    assign wp_cur = create_ok_reg ? '0 : wp_q;
    assign rp_adv = (rp_cur == PW'(PIPE_DEPTH - 1)) ? '0 : rp_cur + PW'(1);
    assign wp_adv = (wp_cur == PW'(PIPE_DEPTH - 1)) ? '0 : wp_cur + PW'(1);
    assign full   = (wp_adv == rp_cur);
    assign empty  = (rp_cur == wp_cur);

    always_comb
    begin
        status_c = mcbf_pkg::ST_OK;
        pout_c   = id_reg;
        report   = live_reg;
        rp_new   = rp_cur;
        wp_new   = wp_cur;
        do_write = 1'b0;
        do_read  = 1'b0;
        clr_use  = 1'b0;
        priority if (func_reg == mcbf_pkg::FN_CREATE)
        begin
            report   = create_ok_reg;
            status_c = create_ok_reg ? mcbf_pkg::ST_OK : mcbf_pkg::ST_NO_PIPE;
            pout_c   = create_ok_reg ? mcbf_pkg::ID_W'(target_reg) : id_reg;
        end
        else if (func_reg > mcbf_pkg::FN_QUERY)
        begin
            status_c = mcbf_pkg::ST_INVALID;
        end
        else if (!live_reg)
        begin
            status_c = mcbf_pkg::ST_INVALID;
        end
        else if (func_reg == mcbf_pkg::FN_WRITE)
        begin
            if (full)
            begin
                status_c = mcbf_pkg::ST_FULL;
            end
            else
            begin
                do_write = 1'b1;
                wp_new   = wp_adv;
            end
        end
        else if (func_reg == mcbf_pkg::FN_READ)
        begin
            if (empty)
            begin
                status_c = mcbf_pkg::ST_EMPTY;
            end
            else
            begin
                do_read = 1'b1;
                rp_new  = rp_adv;
            end
        end
        else if (func_reg == mcbf_pkg::FN_CLOSE)
        begin
            clr_use = 1'b1;
            report  = 1'b0;
        end
        else
        begin
            status_c = mcbf_pkg::ST_OK;
        end
    end

    // free slots after the operation, ring of PIPE_DEPTH holding one less
    assign fv_c = (rp_new > wp_new)
                ? ({1'b0, rp_new} - {1'b0, wp_new} - (PW+1)'(1))
                : ({1'b0, rp_new} + (PW+1)'(PIPE_DEPTH) - {1'b0, wp_new} - (PW+1)'(1));
    assign free_sat = (32'(fv_c) > 32'(mcbf_pkg::FREE_MAX))
                    ? mcbf_pkg::FREE_MAX : mcbf_pkg::FREE_W'(fv_c);
    assign free_c   = report ? free_sat : '0;
    assign hasd_c   = report && (rp_new != wp_new);
    assign addr_c   = base_reg + AW'(do_write ? wp_cur : rp_cur);

    always_comb
    begin
        in_use_next = in_use_reg;
        if (create_ok_reg)
        begin
            in_use_next[target_reg] = 1'b1;
        end
        if (clr_use)
        begin
            in_use_next[target_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else if (cmd.execute)
        begin
            in_use_reg <= in_use_next;
        end
    end

    // pointer tables
    always_ff @(posedge clk)
    begin
        if (cmd.execute && (create_ok_reg || do_read))
        begin
            rp_mem[target_reg] <= rp_new;
        end
        if (cmd.lookup)
        begin
            rp_q <= rp_mem[target_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && (create_ok_reg || do_write))
        begin
            wp_mem[target_reg] <= wp_new;
        end
        if (cmd.lookup)
        begin
            wp_q <= wp_mem[target_c];
        end
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (cmd.execute && do_write)
        begin
            byte_mem[addr_c] <= din_reg;
        end
        if (cmd.execute)
        begin
            rdata_reg <= byte_mem[addr_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg   <= status_c;
            pout_reg     <= pout_c;
            free_reg     <= free_c;
            hasd_reg     <= hasd_c;
            last_out_reg <= last_reg;
            rdok_reg     <= do_read;
        end
    end

    assign status     = status_reg;
    assign pipe_out   = pout_reg;
    assign data_out   = rdok_reg ? rdata_reg : '0;
    assign bytes_free = free_reg;
    assign has_data   = hasd_reg;
    assign last_out   = last_out_reg;

endmodule

// ----- sv/multi_channel_byte_fifo_table.sv -----
// top level of the multi-channel byte fifo table
// depends on mcbf_pkg, mcbf_ctrl, mcbf_dpath
//
// channel   handshake             payload
// input     in_valid / in_stall   func, pipe_id, data_in, last_in_call
// output    out_valid / out_stall status, pipe_out, data_out, bytes_free, has_data, last_out
//
// each word passes through three steps: accept, pointer table lookup, execute with byte store access
// the pointer tables are read in lookup and written in execute; the byte store is accessed in execute
// a new word is taken while the previous result still waits on out_stall
// execute holds while a result waits, so a stalled output also holds off new input words
// in the datapath reset clears the slot flags only; no clearing pass, pointers are set by create

module multi_channel_byte_fifo_table
#(
    parameter int NUM_PIPES  = 16,
    parameter int PIPE_DEPTH = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mcbf_pkg::FUNC_W-1:0]   func,
    input  logic [mcbf_pkg::ID_W-1:0]     pipe_id,
    input  logic [mcbf_pkg::BYTE_W-1:0]   data_in,
    input  logic                          last_in_call,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mcbf_pkg::STATUS_W-1:0] status,
    output logic [mcbf_pkg::ID_W-1:0]     pipe_out,
    output logic [mcbf_pkg::BYTE_W-1:0]   data_out,
    output logic [mcbf_pkg::FREE_W-1:0]   bytes_free,
    output logic                          has_data,
    output logic                          last_out
);

    mcbf_pkg::cmd_t cmd;

    mcbf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mcbf_dpath
    #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .pipe_id      (pipe_id),
        .data_in      (data_in),
        .last_in_call (last_in_call),
        .status       (status),
        .pipe_out     (pipe_out),
        .data_out     (data_out),
        .bytes_free   (bytes_free),
        .has_data     (has_data),
        .last_out     (last_out)
    );

endmodule

// ----- test/tb.sv -----
// self-checking testbench for multi_channel_byte_fifo_table: queued words, random idles, scoreboard
// depends on mcbf_pkg and multi_channel_byte_fifo_table

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FUNC_W      = mcbf_pkg::FUNC_W;
    localparam int ID_W        = mcbf_pkg::ID_W;
    localparam int BYTE_W      = mcbf_pkg::BYTE_W;
    localparam int STATUS_W    = mcbf_pkg::STATUS_W;
    localparam int FREE_W      = mcbf_pkg::FREE_W;
    localparam int NUM_PIPES   = 16;
    localparam int PIPE_DEPTH  = 4096;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   pipe_id;
        logic [BYTE_W-1:0] data;
        logic              last;
    } word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     pipe;
        logic [BYTE_W-1:0]   data;
        logic [FREE_W-1:0]   free;
        logic                ready;
        logic                last;
    } result_t;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func         = '0;
    logic [ID_W-1:0]     pipe_id      = '0;
    logic [BYTE_W-1:0]   data_in      = '0;
    logic                last_in_call = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     pipe_out;
    logic [BYTE_W-1:0]   data_out;
    logic [FREE_W-1:0]   bytes_free;
    logic                has_data;
    logic                last_out;

    word_t   word_q[$];
    result_t result_q[$];

    // pipe table as the block should hold it
    logic              pipe_live  [NUM_PIPES];
    int                rd_ptr     [NUM_PIPES];
    int                wr_ptr     [NUM_PIPES];
    logic [BYTE_W-1:0] pipe_bytes [NUM_PIPES][PIPE_DEPTH];

    // coarse view used only to shape the stimulus
    logic gen_open [NUM_PIPES];
    int   gen_cnt  [NUM_PIPES];

    logic in_taken  = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   cyc       = 0;
    int   errors    = 0;
    int   words_in  = 0;
    int   results   = 0;
    int   st_seen [8];
    logic quiet;

    assign quiet = (cyc >= 1500) && (cyc < 4500);

    multi_channel_byte_fifo_table #(
        .NUM_PIPES  (NUM_PIPES),
        .PIPE_DEPTH (PIPE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pipe_id      (pipe_id),
        .data_in      (data_in),
        .last_in_call (last_in_call),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .pipe_out     (pipe_out),
        .data_out     (data_out),
        .bytes_free   (bytes_free),
        .has_data     (has_data),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t apply_word(word_t w);
        result_t r;
        int      tgt;
        int      nxt;
        int      fr;
        logic    live;
        logic    show;
        r        = '0;
        r.status = mcbf_pkg::ST_OK;
        r.pipe   = w.pipe_id;
        r.last   = w.last;
        tgt      = int'(w.pipe_id);
        live     = (int'(w.pipe_id) < NUM_PIPES) && pipe_live[w.pipe_id];
        show     = live;
        if (w.func == mcbf_pkg::FN_CREATE)
        begin
            show     = 1'b0;
            r.status = mcbf_pkg::ST_NO_PIPE;
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                if (!pipe_live[i] && !show)
                begin
                    pipe_live[i] = 1'b1;
                    rd_ptr[i]    = 0;
                    wr_ptr[i]    = 0;
                    r.status     = mcbf_pkg::ST_OK;
                    r.pipe       = ID_W'(i);
                    tgt          = i;
                    show         = 1'b1;
                end
            end
        end
        else if (w.func > mcbf_pkg::FN_QUERY || !live)
        begin
            r.status = mcbf_pkg::ST_INVALID;
        end
        else if (w.func == mcbf_pkg::FN_WRITE)
        begin
            nxt = (wr_ptr[tgt] + 1) % PIPE_DEPTH;
            if (nxt == rd_ptr[tgt])
            begin
                r.status = mcbf_pkg::ST_FULL;
            end
            else
            begin
                pipe_bytes[tgt][wr_ptr[tgt]] = w.data;
                wr_ptr[tgt] = nxt;
            end
        end
        else if (w.func == mcbf_pkg::FN_READ)
        begin
            if (rd_ptr[tgt] == wr_ptr[tgt])
            begin
                r.status = mcbf_pkg::ST_EMPTY;
            end
            else
            begin
                r.data      = pipe_bytes[tgt][rd_ptr[tgt]];
                rd_ptr[tgt] = (rd_ptr[tgt] + 1) % PIPE_DEPTH;
            end
        end
        else if (w.func == mcbf_pkg::FN_CLOSE)
        begin
            pipe_live[tgt] = 1'b0;
            show           = 1'b0;
        end
        if (show)
        begin
            fr = (rd_ptr[tgt] + PIPE_DEPTH - wr_ptr[tgt] - 1) % PIPE_DEPTH;
            r.free  = (fr > int'(mcbf_pkg::FREE_MAX)) ? mcbf_pkg::FREE_MAX : FREE_W'(fr);
            r.ready = (rd_ptr[tgt] != wr_ptr[tgt]);
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // input acceptance and result checking
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            cyc      <= cyc + 1;
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                result_q.push_back(apply_word('{func, pipe_id, data_in, last_in_call}));
                words_in++;
            end
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result word with nothing pending: status %0d pipe %0d",
                           status, pipe_out);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("pipe_out", 16'(want.pipe), 16'(pipe_out));
                    check_field("data_out", 16'(want.data), 16'(data_out));
                    check_field("bytes_free", 16'(want.free), 16'(bytes_free));
                    check_field("has_data", 16'(want.ready), 16'(has_data));
                    check_field("last_out", 16'(want.last), 16'(last_out));
                    st_seen[want.status]++;
                    results++;
                end
            end
        end
        else
        begin
            in_taken <= 1'b0;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        word_t w;
        if (!in_valid || in_taken)
        begin
            if (word_q.size() != 0 && (quiet || $urandom_range(99) >= 7))
            begin
                w = word_q.pop_front();
                in_valid     <= 1'b1;
                func         <= w.func;
                pipe_id      <= w.pipe_id;
                data_in      <= w.data;
                last_in_call <= w.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_seen)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_seen <= 1'b1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    task automatic push_word(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                             input logic [BYTE_W-1:0] d, input logic l);
        logic claimed;
        word_q.push_back('{f, id, d, l});
        claimed = 1'b0;
        unique case (f)
            mcbf_pkg::FN_CREATE:
            begin
                for (int i = 0; i < NUM_PIPES; i++)
                begin
                    if (!gen_open[i] && !claimed)
                    begin
                        gen_open[i] = 1'b1;
                        gen_cnt[i]  = 0;
                        claimed     = 1'b1;
                    end
                end
            end
            mcbf_pkg::FN_WRITE:
            begin
                if (gen_open[id] && gen_cnt[id] < PIPE_DEPTH - 1)
                    gen_cnt[id]++;
            end
            mcbf_pkg::FN_READ:
            begin
                if (gen_open[id] && gen_cnt[id] > 0)
                    gen_cnt[id]--;
            end
            mcbf_pkg::FN_CLOSE:
            begin
                gen_open[id] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_open();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < NUM_PIPES; i++)
            if (gen_open[i])
                n++;
        if (n == 0)
            return -1;
        k = $urandom_range(n - 1);
        for (int i = 0; i < NUM_PIPES; i++)
        begin
            if (gen_open[i])
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return -1;
    endfunction

    // transfers of random content on open pipes, with some noise
    task automatic mix_words(input int n);
        int sent;
        int p;
        int len;
        int r;
        sent = 0;
        while (sent < n)
        begin
            r   = $urandom_range(99);
            p   = pick_open();
            len = $urandom_range(8, 1);
            if (r < 8 || (p < 0 && r < 80))
            begin
                push_word(mcbf_pkg::FN_CREATE, ID_W'($urandom_range(15)),
                          BYTE_W'($urandom_range(255)), 1'b1);
                len = 1;
            end
            else if (r < 42)
            begin
                for (int k = 0; k < len; k++)
                    push_word(mcbf_pkg::FN_WRITE, ID_W'(p), BYTE_W'($urandom_range(255)),
                              k == len - 1);
            end
            else if (r < 66)
            begin
                for (int k = 0; k < len; k++)
                    push_word(mcbf_pkg::FN_READ, ID_W'(p), BYTE_W'($urandom_range(255)),
                              k == len - 1);
            end
            else if (r < 72)
            begin
                push_word(mcbf_pkg::FN_CLOSE, ID_W'(p), BYTE_W'($urandom_range(255)), 1'b1);
                len = 1;
            end
            else if (r < 80)
            begin
                push_word(mcbf_pkg::FN_QUERY, ID_W'(p), BYTE_W'($urandom_range(255)),
                          1'($urandom_range(1)));
                len = 1;
            end
            else
            begin
                push_word(FUNC_W'($urandom_range(7)), ID_W'($urandom_range(15)),
                          BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                len = 1;
            end
            sent += len;
        end
    endtask

    task automatic wait_quiet();
        while (word_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_PIPES; i++)
        begin
            pipe_live[i] = 1'b0;
            rd_ptr[i]    = 0;
            wr_ptr[i]    = 0;
            gen_open[i]  = 1'b0;
            gen_cnt[i]   = 0;
        end
        foreach (st_seen[i])
            st_seen[i] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        push_word(mcbf_pkg::FN_CREATE, 4'd9, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_WRITE, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_WRITE, 4'd0, 8'hff, 1'b1);
        push_word(mcbf_pkg::FN_QUERY, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_READ, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_READ, 4'd0, 8'hff, 1'b1);
        push_word(mcbf_pkg::FN_READ, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_WRITE, 4'd15, 8'ha5, 1'b1);
        push_word(mcbf_pkg::FN_READ, 4'd15, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_QUERY, 4'd15, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_CLOSE, 4'd15, 8'h00, 1'b1);
        push_word(3'd5, 4'd0, 8'h00, 1'b0);
        push_word(3'd6, 4'd0, 8'hff, 1'b1);
        push_word(3'd7, 4'd15, 8'h5a, 1'b0);
        push_word(mcbf_pkg::FN_CREATE, 4'd15, 8'hff, 1'b1);
        push_word(mcbf_pkg::FN_CLOSE, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_QUERY, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_CREATE, 4'd0, 8'h00, 1'b1);
        push_word(mcbf_pkg::FN_READ, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_CLOSE, 4'd0, 8'h00, 1'b0);
        push_word(mcbf_pkg::FN_CLOSE, 4'd1, 8'h00, 1'b1);

        mix_words(700);
        wait_quiet();

        // receiver holds off while the table fills up and more words queue
        @(posedge clk);
        hold_req = 1'b1;
        for (int i = 0; i <= NUM_PIPES; i++)
            push_word(mcbf_pkg::FN_CREATE, ID_W'($urandom_range(15)),
                      BYTE_W'($urandom_range(255)), 1'b1);
        mix_words(300);
        wait_quiet();

        // free every pipe and start over
        for (int i = 0; i < NUM_PIPES; i++)
            if (gen_open[i])
                push_word(mcbf_pkg::FN_CLOSE, ID_W'(i), 8'h00, 1'b1);

        mix_words(800);
        wait_quiet();
        repeat (12) @(posedge clk);

        $display("%0d words in, %0d results checked, output hold-off and idle-free stretch run",
                 words_in, results);
        $display("status mix: ok %0d, invalid %0d, no pipe %0d, empty %0d, full %0d",
                 st_seen[mcbf_pkg::ST_OK], st_seen[mcbf_pkg::ST_INVALID],
                 st_seen[mcbf_pkg::ST_NO_PIPE], st_seen[mcbf_pkg::ST_EMPTY],
                 st_seen[mcbf_pkg::ST_FULL]);
        if (errors == 0 && result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results pending", result_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- multi_channel_byte_fifo_table.f -----
sv/mcbf_pkg.sv
sv/mcbf_ctrl.sv
sv/mcbf_dpath.sv
sv/multi_channel_byte_fifo_table.sv
test/tb.sv
